// File: hw/rtl/csfw_pkg.sv
// Package for the counting semaphore with FIFO wait queue.
// Holds operation and status codes, sequencer states and count limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csfw_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam int COUNT_W = 16;
  localparam int PORT_ID_W = 8;

  localparam logic signed [COUNT_W-1:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] CNT_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    FN_TRY    = 2'd0,
    FN_WAIT   = 2'd1,
    FN_CANCEL = 2'd2,
    FN_SIGNAL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_QFULL    = 2'd1,
    STS_SAT      = 2'd2,
    STS_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_POP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/counting_semaphore_fifo_waiters_unit.sv
// Counting semaphore with FIFO wait queue. Sequence from accept to result register: try-acquire
// and wait go through EXEC and DONE; signal adds POP when it releases a waiter (head read); cancel
// adds SEARCH over the k ids searched and SHIFT over the m entries compacted before DONE.
// One transaction in flight: in_stall is high from accept until the result is loaded, so no new
// request is taken before then, and a stalled result also blocks the load and the next request.
// Synchronous active-low reset: count 0, queue empty; queue RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_fifo_waiters_unit
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_func,
  input  wire logic [PORT_ID_W-1:0]       in_thread_id,
  input  wire logic                       in_drop_if_idle,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_granted,
  output logic                            out_blocked,
  output logic                            out_woken_valid,
  output logic [PORT_ID_W-1:0]            out_woken_id,
  output logic                            out_cancel_hit,
  output logic [1:0]                      out_status,
  output logic signed [COUNT_W-1:0]       out_count_now
);

  localparam int AddrW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW    = CntW + 1;
  localparam int CopyW = (ID_BITS < PORT_ID_W) ? ID_BITS : PORT_ID_W;

  state_t state_r, state_nxt;
  func_t  func_r, func_nxt;
  logic [ID_BITS-1:0] tid_r, tid_nxt, tid_in;
  logic drop_r, drop_nxt;

  logic signed [COUNT_W-1:0] count_r, count_nxt;
  logic [CntW-1:0]  total_r, total_nxt;
  logic [AddrW-1:0] head_r, head_nxt;
  logic [CntW-1:0]  idx_r, idx_nxt;

  logic res_granted_r, res_granted_nxt;
  logic res_blocked_r, res_blocked_nxt;
  logic res_wvalid_r, res_wvalid_nxt;
  logic [ID_BITS-1:0] res_wid_r, res_wid_nxt;
  logic res_hit_r, res_hit_nxt;
  status_t res_status_r, res_status_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_granted_r, out_blocked_r, out_wvalid_r, out_hit_r;
  logic [ID_BITS-1:0] out_wid_r;
  status_t out_status_r;
  logic signed [COUNT_W-1:0] out_count_r;
  logic out_load;

  logic ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ID_BITS-1:0] ram_wdata, ram_rdata;

  logic cnt_pos, cnt_min, cnt_max, cnt_neg, q_empty, q_full;
  logic more, more2, id_hit, sig_pop;
  logic [PW-1:0] idx_p1, idx_p2, total_w;

  // logical queue offset to physical RAM address (circular buffer)
  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                            input logic [PW-1:0] off);
    logic [PW-1:0] sum;
    sum = PW'(head) + off;
    if (sum >= PW'(QUEUE_DEPTH)) begin
      sum = sum - PW'(QUEUE_DEPTH);
    end
    return AddrW'(sum);
  endfunction

  always_comb begin
    tid_in = '0;
    for (int b = 0; b < CopyW; b++) begin
      tid_in[b] = in_thread_id[b];
    end
  end

  assign cnt_pos = (count_r > 0);
  assign cnt_min = (count_r == CNT_MIN);
  assign cnt_max = (count_r == CNT_MAX);
  assign cnt_neg = count_r[COUNT_W-1];
  assign q_empty = (total_r == '0);
  assign q_full  = (total_r == CntW'(QUEUE_DEPTH));
  assign total_w = PW'(total_r);
  assign idx_p1  = PW'(idx_r) + PW'(1);
  assign idx_p2  = PW'(idx_r) + PW'(2);
  assign more    = (idx_p1 < total_w);
  assign more2   = (idx_p2 < total_w);
  assign id_hit  = (ram_rdata == tid_r);
  assign sig_pop = !(drop_r && q_empty) && !cnt_max && cnt_neg && !q_empty;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_r)
          FN_CANCEL: state_nxt = q_empty ? S_DONE : S_SEARCH;
          FN_SIGNAL: state_nxt = sig_pop ? S_POP : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_SEARCH: begin
        if (more) begin
          state_nxt = id_hit ? S_SHIFT : S_SEARCH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: state_nxt = more2 ? S_SHIFT : S_DONE;
      S_POP:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and queue RAM control
  always_comb begin
    func_nxt        = func_r;
    tid_nxt         = tid_r;
    drop_nxt        = drop_r;
    count_nxt       = count_r;
    total_nxt       = total_r;
    head_nxt        = head_r;
    idx_nxt         = idx_r;
    res_granted_nxt = res_granted_r;
    res_blocked_nxt = res_blocked_r;
    res_wvalid_nxt  = res_wvalid_r;
    res_wid_nxt     = res_wid_r;
    res_hit_nxt     = res_hit_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    ram_we          = 1'b0;
    ram_waddr       = phys(head_r, total_w);
    ram_wdata       = tid_r;
    ram_re          = 1'b0;
    ram_raddr       = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt        = func_t'(in_func);
          tid_nxt         = tid_in;
          drop_nxt        = in_drop_if_idle;
          res_granted_nxt = 1'b0;
          res_blocked_nxt = 1'b0;
          res_wvalid_nxt  = 1'b0;
          res_wid_nxt     = '0;
          res_hit_nxt     = 1'b0;
          res_status_nxt  = STS_OK;
        end
      end
      S_EXEC: begin
        case (func_r)
          FN_TRY: begin
            if (cnt_pos) begin
              count_nxt       = count_r - 16'sd1;
              res_granted_nxt = 1'b1;
            end
          end
          FN_WAIT: begin
            if (cnt_pos) begin
              count_nxt       = count_r - 16'sd1;
              res_granted_nxt = 1'b1;
            end else if (cnt_min) begin
              res_status_nxt = STS_SAT;
            end else if (q_full) begin
              res_status_nxt = STS_QFULL;
            end else begin
              ram_we          = 1'b1;
              count_nxt       = count_r - 16'sd1;
              total_nxt       = total_r + CntW'(1);
              res_blocked_nxt = 1'b1;
            end
          end
          FN_CANCEL: begin
            idx_nxt = '0;
            ram_re  = !q_empty;
          end
          default: begin
            if (drop_r && q_empty) begin
              // ignored
            end else if (cnt_max) begin
              res_status_nxt = STS_SAT;
            end else begin
              count_nxt = count_r + 16'sd1;
              if (cnt_neg) begin
                if (q_empty) begin
                  res_status_nxt = STS_MISMATCH;
                end else begin
                  ram_re = 1'b1;
                end
              end
            end
          end
        endcase
      end
      S_SEARCH: begin
        // while searching, a read of the next entry is in flight whenever one remains
        ram_re    = more;
        ram_raddr = phys(head_r, idx_p1);
        if (id_hit) begin
          if (!more) begin
            total_nxt   = total_r - CntW'(1);
            res_hit_nxt = 1'b1;
            if (cnt_max) res_status_nxt = STS_SAT;
            else         count_nxt = count_r + 16'sd1;
          end
        end else if (more) begin
          idx_nxt = CntW'(idx_p1);
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, PW'(idx_r));
        ram_wdata = ram_rdata;
        ram_re    = more2;
        ram_raddr = phys(head_r, idx_p2);
        if (more2) begin
          idx_nxt = CntW'(idx_p1);
        end else begin
          total_nxt   = total_r - CntW'(1);
          res_hit_nxt = 1'b1;
          if (cnt_max) res_status_nxt = STS_SAT;
          else         count_nxt = count_r + 16'sd1;
        end
      end
      S_POP: begin
        res_wvalid_nxt = 1'b1;
        res_wid_nxt    = ram_rdata;
        total_nxt      = total_r - CntW'(1);
        head_nxt       = (head_r == AddrW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AddrW'(1);
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    tid_r         <= tid_nxt;
    drop_r        <= drop_nxt;
    idx_r         <= idx_nxt;
    res_granted_r <= res_granted_nxt;
    res_blocked_r <= res_blocked_nxt;
    res_wvalid_r  <= res_wvalid_nxt;
    res_wid_r     <= res_wid_nxt;
    res_hit_r     <= res_hit_nxt;
    res_status_r  <= res_status_nxt;
    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_blocked_r <= res_blocked_r;
      out_wvalid_r  <= res_wvalid_r;
      out_wid_r     <= res_wid_r;
      out_hit_r     <= res_hit_r;
      out_status_r  <= res_status_r;
      out_count_r   <= count_r;
    end
  end

  csfw_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_blocked     = out_blocked_r;
  assign out_woken_valid = out_wvalid_r;
  assign out_cancel_hit  = out_hit_r;
  assign out_status      = out_status_r;
  assign out_count_now   = out_count_r;

  always_comb begin
    out_woken_id = '0;
    for (int b = 0; b < CopyW; b++) begin
      out_woken_id[b] = out_wid_r[b];
    end
  end

  // queue occupancy never exceeds its depth
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CntW'(QUEUE_DEPTH))
    else $error("waiter total above queue depth");

  // between transactions, a negative count goes with a non-empty queue and vice versa
  a_count_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_neg == !q_empty))
    else $error("semaphore count and waiter queue disagree");

  // a released waiter leaves the queue
  a_pop_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (total_r == $past(total_r) - CntW'(1)))
    else $error("pop did not shrink the queue");

  // a result appears only after the sequencer finishes
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside the done state");

  // granted and blocked are exclusive
  a_grant_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_granted_r && out_blocked_r))
    else $error("result both granted and blocked");

endmodule

`default_nettype wire

// File: hw/rtl/csfw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the waiter id queue; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
